// File: rtl/iss_pkg.sv
// Package for the indexed sequence store: sizes, operation and status codes,
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package iss_pkg;
  localparam int CAPACITY = 256;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam int DW = 32;
  localparam int OPW = 2;
  localparam int STW = 2;

  localparam logic [OPW-1:0] OP_READ   = 2'd0;
  localparam logic [OPW-1:0] OP_INSERT = 2'd1;
  localparam logic [OPW-1:0] OP_REMOVE = 2'd2;

  localparam logic [STW-1:0] ST_DONE  = 2'd0;
  localparam logic [STW-1:0] ST_RANGE = 2'd1;
  localparam logic [STW-1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] K_FAIL = 2'd0;
  localparam logic [1:0] K_RD   = 2'd1;
  localparam logic [1:0] K_INS  = 2'd2;
  localparam logic [1:0] K_REM  = 2'd3;

  localparam logic [1:0] RV_ZERO = 2'd0;
  localparam logic [1:0] RV_DATA = 2'd1;
  localparam logic [1:0] RV_NEG1 = 2'd2;

  typedef struct packed {
    logic latch;
    logic decide;
    logic rd;
    logic wr_shift;
    logic wr_val;
    logic ptr_step;
    logic cnt_step;
    logic load_out;
  } iss_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       shift_done;
    logic       out_free;
  } iss_sts_t;
endpackage
`default_nettype wire

// File: rtl/iss_if.sv
// Valid/ready channel interfaces for the input and result items.
// Uses iss_pkg for field widths.
`default_nettype none
interface iss_in_if;
  logic                          valid;
  logic                          ready;
  logic [iss_pkg::OPW-1:0]       operation;
  logic [iss_pkg::CW-1:0]        index;
  logic signed [iss_pkg::DW-1:0] value;
  modport source (output valid, operation, index, value, input ready);
  modport sink (input valid, operation, index, value, output ready);
endinterface

interface iss_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [iss_pkg::DW-1:0] read_value;
  logic [iss_pkg::STW-1:0]       status;
  logic [iss_pkg::CW-1:0]        entry_count;
  modport source (output valid, read_value, status, entry_count, input ready);
  modport sink (input valid, read_value, status, entry_count, output ready);
endinterface
`default_nettype wire

// File: rtl/indexed_sequence_store.sv
// Indexed sequence store: up to 256 signed 32-bit entries, read/insert/remove by index.
// One item at a time: accept latches it, decide follows; a read or refused item then
// loads its result, an insert at i first moves count - i entries, a remove at i
// count - 1 - i, one per read/write state pair of the one-port entry memory. Next
// item accepted after the result loads; a stalled result holds the input.
// Reset empties the store (count 0), entry memory not cleared. Uses iss_pkg/if/ctrl/dp.
`default_nettype none
module indexed_sequence_store (
  input  wire logic   clk,
  input  wire logic   rst_n,
  iss_in_if.sink      in_ch,
  iss_out_if.source   out_ch
);
  iss_pkg::iss_cmd_t cmd;
  iss_pkg::iss_sts_t sts;

  iss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  iss_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_ch.operation),
    .in_index        (in_ch.index),
    .in_value        (in_ch.value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_read_value  (out_ch.read_value),
    .out_status      (out_ch.status),
    .out_entry_count (out_ch.entry_count)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while another is in progress");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.entry_count <= iss_pkg::CW'(iss_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == iss_pkg::ST_FULL
      |-> out_ch.entry_count == iss_pkg::CW'(iss_pkg::CAPACITY))
    else $error("full status with store not full");
endmodule
`default_nettype wire

// File: rtl/iss_ctrl.sv
// Controller state machine of the indexed sequence store.
// Uses iss_pkg command/status structs; drives iss_dp.
`default_nettype none
module iss_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire iss_pkg::iss_sts_t sts,
  output iss_pkg::iss_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_SHWR = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (sts.kind == iss_pkg::K_RD) begin
          cmd.rd = 1'b1;
          state_nxt = S_RESP;
        end else if (sts.kind == iss_pkg::K_FAIL) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.shift_done) begin
          cmd.cnt_step = 1'b1;
          cmd.wr_val = (sts.kind == iss_pkg::K_INS);
          state_nxt = S_RESP;
        end else begin
          cmd.rd = 1'b1;
          state_nxt = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        cmd.ptr_step = 1'b1;
        state_nxt = S_CHK;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/iss_dp.sv
// Datapath of the indexed sequence store: entry memory, count, shift pointer,
// item latch and result register. Uses iss_pkg; commanded by iss_ctrl.
`default_nettype none
module iss_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire iss_pkg::iss_cmd_t             cmd,
  output iss_pkg::iss_sts_t                  sts,
  input  wire logic [iss_pkg::OPW-1:0]       in_operation,
  input  wire logic [iss_pkg::CW-1:0]        in_index,
  input  wire logic signed [iss_pkg::DW-1:0] in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [iss_pkg::DW-1:0]      out_read_value,
  output logic [iss_pkg::STW-1:0]            out_status,
  output logic [iss_pkg::CW-1:0]             out_entry_count
);
  localparam logic [iss_pkg::CW-1:0] CAP = iss_pkg::CW'(iss_pkg::CAPACITY);

  logic [iss_pkg::DW-1:0]  mem [iss_pkg::CAPACITY];
  logic [iss_pkg::OPW-1:0] op_r;
  logic [iss_pkg::CW-1:0]  idx_r, cnt_r, ptr_r;
  logic [iss_pkg::DW-1:0]  val_r, rdata_r;
  logic [iss_pkg::STW-1:0] st_r, st_nxt;
  logic [1:0]              rsel_r, rsel_nxt, kind;
  logic [iss_pkg::CW-1:0]  rd_ptr, ptr_nxt;
  logic [iss_pkg::CW:0]    ptr_inc;
  logic                    out_valid_r;
  logic [iss_pkg::DW-1:0]  rv;

  assign ptr_inc = {1'b0, ptr_r} + 1'b1;

  always_comb begin
    kind = iss_pkg::K_FAIL;
    st_nxt = iss_pkg::ST_RANGE;
    rsel_nxt = iss_pkg::RV_ZERO;
    rd_ptr = ptr_r - 1'b1;
    ptr_nxt = idx_r;
    case (op_r)
      iss_pkg::OP_READ: begin
        rd_ptr = idx_r;
        rsel_nxt = iss_pkg::RV_NEG1;
        if (idx_r < cnt_r) begin
          kind = iss_pkg::K_RD;
          st_nxt = iss_pkg::ST_DONE;
          rsel_nxt = iss_pkg::RV_DATA;
        end
      end
      iss_pkg::OP_INSERT: begin
        ptr_nxt = cnt_r;
        if (idx_r > cnt_r) begin
          st_nxt = iss_pkg::ST_RANGE;
        end else if (cnt_r == CAP) begin
          st_nxt = iss_pkg::ST_FULL;
        end else begin
          kind = iss_pkg::K_INS;
          st_nxt = iss_pkg::ST_DONE;
        end
      end
      iss_pkg::OP_REMOVE: begin
        rd_ptr = ptr_inc[iss_pkg::CW-1:0];
        if (idx_r < cnt_r) begin
          kind = iss_pkg::K_REM;
          st_nxt = iss_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
  end

  assign sts.kind = kind;
  assign sts.shift_done = (op_r == iss_pkg::OP_INSERT) ? (ptr_r == idx_r)
                                                       : (ptr_inc >= {1'b0, cnt_r});
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.wr_shift || cmd.wr_val) begin
      mem[ptr_r[iss_pkg::AW-1:0]] <= cmd.wr_val ? val_r : rdata_r;
    end
    if (cmd.rd) begin
      rdata_r <= mem[rd_ptr[iss_pkg::AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r <= in_operation;
      idx_r <= in_index;
      val_r <= in_value;
    end
    if (cmd.decide) begin
      st_r <= st_nxt;
      rsel_r <= rsel_nxt;
      ptr_r <= ptr_nxt;
    end else if (cmd.ptr_step) begin
      ptr_r <= (op_r == iss_pkg::OP_INSERT) ? ptr_r - 1'b1 : ptr_inc[iss_pkg::CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_step) begin
      cnt_r <= (op_r == iss_pkg::OP_INSERT) ? cnt_r + 1'b1 : cnt_r - 1'b1;
    end
  end

  always_comb begin
    case (rsel_r)
      iss_pkg::RV_DATA: rv = rdata_r;
      iss_pkg::RV_NEG1: rv = '1;
      default:          rv = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_read_value <= rv;
      out_status <= st_r;
      out_entry_count <= cnt_r;
    end
  end

  assign out_valid = out_valid_r;
endmodule
`default_nettype wire

// File: tb/iss_tb_if.sv
`timescale 1ns / 100ps
// Testbench-side note: channel interfaces come from rtl/iss_if.sv; this file
// holds the checker's shared types. Depends on iss_pkg.
package iss_tb_pkg;
  import iss_pkg::*;
  typedef struct {
    logic signed [DW-1:0] read_value;
    logic [STW-1:0]       status;
    logic [CW-1:0]        entry_count;
  } iss_result_t;
endpackage

// File: tb/iss_checker.sv
`timescale 1ns / 100ps
// Checker for the indexed sequence store: models the entry list, predicts one
// result per accepted item and compares. Depends on iss_pkg, iss_tb_pkg, iss_if.
module iss_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  iss_in_if         in_ch,
  iss_out_if        out_ch,
  output int        fail_count,
  output int        pending
);
  import iss_pkg::*;
  import iss_tb_pkg::*;

  logic signed [DW-1:0] list_q[$];
  iss_result_t          expected_q[$];

  function automatic iss_result_t apply_op(logic [OPW-1:0] op, logic [CW-1:0] idx,
                                           logic signed [DW-1:0] val);
    iss_result_t r;
    int n;
    n = list_q.size();
    r.read_value = '0;
    r.status = ST_DONE;
    if (op == OP_READ) begin
      if (idx < n) begin
        r.read_value = list_q[idx];
      end else begin
        r.read_value = -1;
        r.status = ST_RANGE;
      end
    end else if (op == OP_INSERT) begin
      if (idx > n) r.status = ST_RANGE;
      else if (n >= CAPACITY) r.status = ST_FULL;
      else list_q.insert(idx, val);
    end else if (op == OP_REMOVE) begin
      if (idx >= n) r.status = ST_RANGE;
      else list_q.delete(idx);
    end else begin
      r.status = ST_RANGE;
    end
    r.entry_count = CW'(list_q.size());
    return r;
  endfunction

  always @(posedge clk) begin
    iss_result_t e;
    if (!rst_n) begin
      fail_count = 0;
      list_q.delete();
      expected_q.delete();
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(apply_op(in_ch.operation, in_ch.index, in_ch.value));
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result item");
          fail_count = fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_ch.read_value !== e.read_value) begin
            $error("read_value expected %0d actual %0d", e.read_value, out_ch.read_value);
            fail_count = fail_count + 1;
          end
          if (out_ch.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_ch.status);
            fail_count = fail_count + 1;
          end
          if (out_ch.entry_count !== e.entry_count) begin
            $error("entry_count expected %0d actual %0d", e.entry_count,
                   out_ch.entry_count);
            fail_count = fail_count + 1;
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// Top of the indexed sequence store testbench: clock, reset, directed and
// random items with random idling, verdict. Depends on iss_pkg, iss_if, iss_checker.
module tb;
  import iss_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_pct = 22;
  int   n_model = 0;
  int   n_full = 0;
  int   n_range = 0;

  iss_in_if  in_ch();
  iss_out_if out_ch();

  indexed_sequence_store dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  iss_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                   .fail_count(fail_count), .pending(pending));

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_READ;
    in_ch.index = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
  end

  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send_item(int op, int idx, int val);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.operation <= OPW'(op);
    in_ch.index <= CW'(idx);
    in_ch.value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_INSERT) begin
      if (idx > n_model) n_range++;
      else if (n_model >= CAPACITY) n_full++;
      else n_model++;
    end else if (op == OP_REMOVE && idx < n_model) begin
      n_model--;
    end
    @(negedge clk) in_ch.valid <= 1'b0;
  endtask

  initial begin
    int k;
    int op;
    @(posedge rst_n);
    send_item(OP_READ, 0, 0);
    send_item(OP_REMOVE, 0, 0);
    send_item(OP_INSERT, 1, 5);
    send_item(OP_INSERT, 0, 32'sh7fffffff);
    send_item(OP_REMOVE, 0, 0);
    send_item(OP_INSERT, 0, 32'sh80000000);
    send_item(OP_INSERT, 1, -1);
    send_item(OP_INSERT, 0, 0);
    send_item(OP_READ, 0, 0);
    send_item(OP_READ, 2, 0);
    send_item(OP_READ, 3, 0);
    send_item(OP_READ, 511, 0);
    send_item(3, 0, 0);
    send_item(OP_REMOVE, 1, 0);
    send_item(OP_REMOVE, 5, 0);
    send_item(OP_INSERT, 256, 1);
    send_item(OP_INSERT, 511, 1);
    // fill to capacity, then refused inserts at head, tail and past tail
    while (n_model < CAPACITY) send_item(OP_INSERT, $urandom_range(n_model), $urandom);
    send_item(OP_INSERT, 0, 1);
    send_item(OP_INSERT, 256, 1);
    send_item(OP_INSERT, 257, 1);
    send_item(OP_READ, 255, 0);
    send_item(OP_READ, 256, 0);
    send_item(OP_REMOVE, 255, 0);
    send_item(OP_REMOVE, 0, 0);
    while (n_model > 0) send_item(OP_REMOVE, $urandom_range(n_model - 1), 0);
    for (k = 0; k < 280; k++) begin
      idle_pct = (k >= 100 && k < 200) ? 0 : 22;
      op = $urandom_range(99);
      if (op < 5)
        send_item($urandom_range(3), $urandom_range(511), $urandom);
      else if (op < 45)
        send_item(OP_INSERT, (n_model < 20 || op < 35) ? $urandom_range(n_model) :
                  $urandom_range(n_model / 4), $urandom);
      else if (op < 75)
        send_item(OP_READ, n_model ? $urandom_range(n_model) : 0, 0);
      else
        send_item(OP_REMOVE, n_model ? $urandom_range(n_model) : 0, $urandom);
    end
    idle_pct = 22;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Ran directed and random reads, inserts and removes, incl. full store.");
    $display("Refused inserts: %0d full, %0d out of range.", n_full, n_range);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
